>>> hw/rtl/fk4_pkg.sv
`timescale 1ns / 1ps
package fk4_pkg;

  // Sine/cosine datapath: signed Q2.30 values carried in 36 bits
  localparam int TRIG_W   = 36;
  localparam int ROT_W    = 16;
  localparam int SERIES_N = 7;
  // reduction + square + three stages per series term + final scale
  localparam int SC_LAT   = 3 * SERIES_N + 3;
  localparam int DIV_W    = 35;
  localparam int RECIP_SH = 34;
  localparam int CFG_W    = 64;
  localparam int ROT_LIMIT = 16384;

  localparam logic signed [TRIG_W-1:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [TRIG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

  // Series divisors split as odd part and power of two, highest term first
  localparam int SIN_ODD [SERIES_N] = '{105, 39, 55, 9, 21, 5, 3};
  localparam int COS_ODD [SERIES_N] = '{91, 33, 45, 7, 15, 3, 1};
  localparam int DIV_SH  [SERIES_N] = '{1, 2, 1, 3, 1, 2, 1};

  typedef enum logic [2:0] {
    REG_LATERAL,
    REG_FORWARD,
    REG_RAIL,
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_SHIFT_XY,
    REG_SHIFT_Z
  } cfg_reg_t;

  // a*b/2^30 truncated toward zero
  function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [127:0] p;
    logic [127:0] m;
    p = a * b;
    m = p[127] ? 128'(-p) : 128'(p);
    m = m >> 30;
    return p[127] ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

endpackage

>>> hw/rtl/fk4_sincos.sv
`timescale 1ns / 1ps
module fk4_sincos #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [ANGLE_WIDTH-1:0]     angle,
  output logic signed [fk4_pkg::TRIG_W-1:0] sin_q30,
  output logic signed [fk4_pkg::TRIG_W-1:0] cos_q30
);
  import fk4_pkg::*;

  localparam int N = SERIES_N;

  logic signed [TRIG_W-1:0] x_ext, x_red;
  logic flip_red;

  // fold into about +-pi/2 by one half-turn
  always_comb begin
    x_ext = TRIG_W'(angle) <<< (33 - ANGLE_WIDTH);
    x_red = x_ext;
    flip_red = 1'b0;
    if (x_ext > HALF_PI_Q30) begin
      x_red = x_ext - PI_Q30;
      flip_red = 1'b1;
    end else if (x_ext < -HALF_PI_Q30) begin
      x_red = x_ext + PI_Q30;
      flip_red = 1'b1;
    end
  end

  logic signed [TRIG_W-1:0] xa, xb, x2b;
  logic fa, fb;

  always_ff @(posedge clk) begin
    if (adv) begin
      xa  <= x_red;
      fa  <= flip_red;
      xb  <= xa;
      fb  <= fa;
      x2b <= TRIG_W'(mul_q30(64'(xa), 64'(xa)));
    end
  end

  logic signed [TRIG_W-1:0] x_s  [N+1];
  logic signed [TRIG_W-1:0] x2_s [N+1];
  logic signed [TRIG_W-1:0] ts_s [N+1];
  logic signed [TRIG_W-1:0] tc_s [N+1];
  logic                     f_s  [N+1];

  assign x_s[0]  = xb;
  assign x2_s[0] = x2b;
  assign f_s[0]  = fb;
  assign ts_s[0] = Q30_ONE;
  assign tc_s[0] = Q30_ONE;

  for (genvar i = 0; i < N; i++) begin : g_term
    localparam logic [DIV_W-1:0] RS = DIV_W'((64'd1 << RECIP_SH) / SIN_ODD[i]);
    localparam logic [DIV_W-1:0] RC = DIV_W'((64'd1 << RECIP_SH) / COS_ODD[i]);
    localparam logic [DIV_W-1:0] OS = DIV_W'(SIN_ODD[i]);
    localparam logic [DIV_W-1:0] OC = DIV_W'(COS_ODD[i]);
    localparam int SH = DIV_SH[i];

    logic signed [TRIG_W-1:0] x_p, x2_p, ns_p, nc_p, x_d, x2_d;
    logic f_p, f_d, negs_d, negc_d;
    logic [DIV_W-1:0] ms_n, mc_n, ms_d, mc_d, qs_d, qc_d;
    logic [2*DIV_W-1:0] ps_n, pc_n;
    logic [DIV_W-1:0] rs, rc, qs, qc;

    // product with the running term
    always_ff @(posedge clk) begin
      if (adv) begin
        x_p  <= x_s[i];
        x2_p <= x2_s[i];
        f_p  <= f_s[i];
        ns_p <= TRIG_W'(mul_q30(64'(x2_s[i]), 64'(ts_s[i])));
        nc_p <= TRIG_W'(mul_q30(64'(x2_s[i]), 64'(tc_s[i])));
      end
    end

    // estimate the quotient by reciprocal
    always_comb begin
      ms_n = DIV_W'(ns_p[TRIG_W-1] ? -ns_p : ns_p) >> SH;
      mc_n = DIV_W'(nc_p[TRIG_W-1] ? -nc_p : nc_p) >> SH;
      ps_n = ms_n * RS;
      pc_n = mc_n * RC;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_d    <= x_p;
        x2_d   <= x2_p;
        f_d    <= f_p;
        negs_d <= ns_p[TRIG_W-1];
        negc_d <= nc_p[TRIG_W-1];
        ms_d   <= ms_n;
        mc_d   <= mc_n;
        qs_d   <= DIV_W'(ps_n >> RECIP_SH);
        qc_d   <= DIV_W'(pc_n >> RECIP_SH);
      end
    end

    // estimate is low by at most one
    always_comb begin
      rs = ms_d - qs_d * OS;
      rc = mc_d - qc_d * OC;
      qs = qs_d + DIV_W'(rs >= OS);
      qc = qc_d + DIV_W'(rc >= OC);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_s[i+1]  <= x_d;
        x2_s[i+1] <= x2_d;
        f_s[i+1]  <= f_d;
        ts_s[i+1] <= negs_d ? Q30_ONE + $signed({1'b0, qs}) : Q30_ONE - $signed({1'b0, qs});
        tc_s[i+1] <= negc_d ? Q30_ONE + $signed({1'b0, qc}) : Q30_ONE - $signed({1'b0, qc});
      end
    end
  end

  logic signed [TRIG_W-1:0] sin_m;
  assign sin_m = TRIG_W'(mul_q30(64'(x_s[N]), 64'(ts_s[N])));

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_q30 <= f_s[N] ? -sin_m : sin_m;
      cos_q30 <= f_s[N] ? -tc_s[N] : tc_s[N];
    end
  end

endmodule

>>> hw/rtl/four_axis_forward_kinematics_unit.sv
`timescale 1ns / 1ps
// Four-axis camera arm forward kinematics.
// Slave stream: one joint vector per transaction in s_tdata; the unit takes a
// transaction whenever s_tready is high and s_tvalid is set.
// Master stream: one 3x4 camera pose per input transaction, in order, in
// m_tdata; held stable until m_tready takes it.
// Configuration: cfg_write with cfg_index/cfg_data loads one register per
// clock; load only while no transaction is in flight.
// Throughput: one transaction per cycle while the output queue is not full. The
// depth is set by the sine/cosine series, seven terms of three stages each
// (multiply, reciprocal, correct), followed by the joint, wrist and camera
// product stages.
// Reset (rst, synchronous): drops everything in flight, empties the output
// queue and loads the identity wrist-to-camera rotation and zero offsets.
// Stall: a two-entry output queue sits after the pipeline; the pipeline keeps
// moving while one pose waits and freezes as a whole, losing nothing, only
// while both entries are full (then s_tready is low).
module four_axis_forward_kinematics_unit #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int LENGTH_WIDTH = 32,
  localparam int IN_W  = ((3 * ANGLE_WIDTH + LENGTH_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((9 * 16 + 3 * LENGTH_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // turret_angle, lift_position, pan_angle, tilt_angle
  input  logic [IN_W-1:0]         s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // pos_x, pos_y, pos_z
  output logic [OUT_W-1:0]        m_tdata,
  input  logic                    cfg_write,
  input  fk4_pkg::cfg_reg_t       cfg_index,
  input  logic [fk4_pkg::CFG_W-1:0] cfg_data
);
  import fk4_pkg::*;

  localparam int AW = ANGLE_WIDTH;
  localparam int LW = LENGTH_WIDTH;
  localparam int HS_W   = (LW > 32) ? LW : 32;
  localparam int SUM_W  = HS_W + 4;
  localparam int PROD_W = TRIG_W + 16;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (LW - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [LW-1:0] lateral_offset, forward_offset, rail_offset, hand_shift_z;
  logic [47:0] hand_rot_row0, hand_rot_row1, hand_rot_row2;
  logic [63:0] hand_shift_xy;
  logic signed [LW:0] rl_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      lateral_offset <= '0;
      forward_offset <= '0;
      rail_offset    <= '0;
      hand_rot_row0  <= 48'd16384;
      hand_rot_row1  <= 48'd1073741824;
      hand_rot_row2  <= 48'd70368744177664;
      hand_shift_xy  <= '0;
      hand_shift_z   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LATERAL:  lateral_offset <= cfg_data[LW-1:0];
        REG_FORWARD:  forward_offset <= cfg_data[LW-1:0];
        REG_RAIL:     rail_offset    <= cfg_data[LW-1:0];
        REG_ROT0:     hand_rot_row0  <= cfg_data[47:0];
        REG_ROT1:     hand_rot_row1  <= cfg_data[47:0];
        REG_ROT2:     hand_rot_row2  <= cfg_data[47:0];
        REG_SHIFT_XY: hand_shift_xy  <= cfg_data;
        REG_SHIFT_Z:  hand_shift_z   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // rail plus forward offset, settled long before any transaction uses it
  always_ff @(posedge clk) begin
    rl_sum <= (LW+1)'(rail_offset) + (LW+1)'(forward_offset);
  end

  logic signed [15:0] h [3][3];
  logic signed [HS_W-1:0] hs [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      h[0][j] = hand_rot_row0[16*j +: 16];
      h[1][j] = hand_rot_row1[16*j +: 16];
      h[2][j] = hand_rot_row2[16*j +: 16];
    end
    hs[0] = HS_W'($signed(hand_shift_xy[31:0]));
    hs[1] = HS_W'($signed(hand_shift_xy[63:32]));
    hs[2] = HS_W'(hand_shift_z);
  end

  // ---------------------------------------------------------------------
  // Flow control: whole pipeline advances unless the output queue is full
  // ---------------------------------------------------------------------
  logic [1:0] fifo_cnt;
  logic adv;

  assign adv = (fifo_cnt != 2'd2);
  assign s_tready = adv;

  // ---------------------------------------------------------------------
  // Sine/cosine of the three angles
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] turret_angle, pan_angle, tilt_angle;
  logic signed [LW-1:0] lift_position;
  logic signed [TRIG_W-1:0] s1, c1, s2, c2, s3, c3;

  assign turret_angle  = s_tdata[AW-1:0];
  assign lift_position = s_tdata[AW+LW-1:AW];
  assign pan_angle     = s_tdata[2*AW+LW-1:AW+LW];
  assign tilt_angle    = s_tdata[3*AW+LW-1:2*AW+LW];

  fk4_sincos #(.ANGLE_WIDTH(AW)) u_turret (
    .clk(clk), .adv(adv), .angle(turret_angle), .sin_q30(s1), .cos_q30(c1)
  );
  fk4_sincos #(.ANGLE_WIDTH(AW)) u_pan (
    .clk(clk), .adv(adv), .angle(pan_angle), .sin_q30(s2), .cos_q30(c2)
  );
  fk4_sincos #(.ANGLE_WIDTH(AW)) u_tilt (
    .clk(clk), .adv(adv), .angle(tilt_angle), .sin_q30(s3), .cos_q30(c3)
  );

  // valid bits and lift travel alongside the series stages
  logic                 v_sc   [SC_LAT];
  logic signed [LW-1:0] lift_d [SC_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SC_LAT; i++) v_sc[i] <= 1'b0;
    end else if (adv) begin
      v_sc[0] <= s_tvalid;
      for (int i = 1; i < SC_LAT; i++) v_sc[i] <= v_sc[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lift_d[0] <= lift_position;
      for (int i = 1; i < SC_LAT; i++) lift_d[i] <= lift_d[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage T1: combined turret+pan angle, wrist position products
  // ---------------------------------------------------------------------
  logic v1, v2, v3;
  logic signed [TRIG_W-1:0] s12_q, c12_q, s3_q, c3_q;
  logic signed [SUM_W-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [LW-1:0] lift_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= v_sc[SC_LAT-1];
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_q  <= TRIG_W'(mul_q30(64'(s1), 64'(c2)) + mul_q30(64'(c1), 64'(s2)));
      c12_q  <= TRIG_W'(mul_q30(64'(c1), 64'(c2)) - mul_q30(64'(s1), 64'(s2)));
      s3_q   <= s3;
      c3_q   <= c3;
      pa_q   <= SUM_W'(mul_q30(64'(lateral_offset), 64'(c1)));
      pb_q   <= SUM_W'(mul_q30(64'(rl_sum), 64'(s1)));
      pc_q   <= SUM_W'(mul_q30(64'(lateral_offset), 64'(s1)));
      pd_q   <= SUM_W'(mul_q30(64'(rl_sum), 64'(c1)));
      lift_1 <= lift_d[SC_LAT-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage T2: wrist rotation and wrist position
  // ---------------------------------------------------------------------
  logic signed [TRIG_W-1:0] rw_q [3][3];
  logic signed [SUM_W-1:0] pw_q [3];
  logic signed [TRIG_W-1:0] m00, m01, m10, m11;

  always_comb begin
    m00 = TRIG_W'(mul_q30(64'(s12_q), 64'(c3_q)));
    m01 = TRIG_W'(mul_q30(64'(s12_q), 64'(s3_q)));
    m10 = TRIG_W'(mul_q30(64'(c12_q), 64'(c3_q)));
    m11 = TRIG_W'(mul_q30(64'(c12_q), 64'(s3_q)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rw_q[0][0] <= -m00;
      rw_q[0][1] <= m01;
      rw_q[0][2] <= c12_q;
      rw_q[1][0] <= m10;
      rw_q[1][1] <= -m11;
      rw_q[1][2] <= s12_q;
      rw_q[2][0] <= s3_q;
      rw_q[2][1] <= c3_q;
      rw_q[2][2] <= '0;
      pw_q[0]    <= pa_q - pb_q;
      pw_q[1]    <= pc_q + pd_q;
      pw_q[2]    <= SUM_W'(lift_1);
    end
  end

  // ---------------------------------------------------------------------
  // Stage T3: products with the wrist-to-camera transform
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_q [3][3][3];
  logic signed [SUM_W-1:0] pt_q [3][3];
  logic signed [SUM_W-1:0] pw3_q [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pw3_q[i] <= pw_q[i];
        for (int j = 0; j < 3; j++) begin
          pt_q[i][j] <= SUM_W'(mul_q30(64'(hs[j]), 64'(rw_q[i][j])));
          for (int k = 0; k < 3; k++) prod_q[i][j][k] <= rw_q[i][k] * h[k][j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final sums: round and clamp rotation to Q2.14, saturate position
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc [3][3];
  logic [ACC_W-1:0] mag [3][3];
  logic [ACC_W-1:0] rmag [3][3];
  logic signed [ROT_W-1:0] rot [3][3];
  logic signed [SUM_W-1:0] psum [3];
  logic signed [SUM_W-1:0] pos [3];
  logic [OUT_W-1:0] out_pack;

  always_comb begin
    out_pack = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc[i][j] = ACC_W'(prod_q[i][j][0]) + ACC_W'(prod_q[i][j][1])
                  + ACC_W'(prod_q[i][j][2]);
        mag[i][j] = acc[i][j][ACC_W-1] ? ACC_W'(-acc[i][j]) : ACC_W'(acc[i][j]);
        rmag[i][j] = (mag[i][j] + (ACC_W'(1) << 29)) >> 30;
        if (rmag[i][j] > ACC_W'(ROT_LIMIT)) rmag[i][j] = ACC_W'(ROT_LIMIT);
        rot[i][j] = acc[i][j][ACC_W-1] ? -$signed(rmag[i][j][ROT_W-1:0])
                                       : $signed(rmag[i][j][ROT_W-1:0]);
        out_pack[16*(3*i+j) +: 16] = rot[i][j];
      end
      psum[i] = pw3_q[i] + pt_q[i][0] + pt_q[i][1] + pt_q[i][2];
      if (psum[i] > POS_MAX) pos[i] = POS_MAX;
      else if (psum[i] < POS_MIN) pos[i] = POS_MIN;
      else pos[i] = psum[i];
      out_pack[144 + LW*i +: LW] = pos[i][LW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Output queue, two entries
  // ---------------------------------------------------------------------
  logic [OUT_W-1:0] fifo_q [2];
  logic wr_ptr, rd_ptr;
  logic push, pop;

  assign push = adv & v3;
  assign pop  = m_tvalid & m_tready;
  assign m_tvalid = (fifo_cnt != 2'd0);
  assign m_tdata  = fifo_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fifo_cnt <= fifo_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_q[wr_ptr] <= out_pack;
  end

endmodule

>>> hw/rtl/fk4_checker.sv
`timescale 1ns / 1ps
module fk4_checker #(
  parameter int OUT_W = 240
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pose presented right after reset");

  // back-pressure on the input only while a pose is waiting
  a_ready_stall: assert property (@(posedge clk) !s_tready |-> m_tvalid)
    else $error("input stalled with no pose pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending pose dropped or changed");

endmodule

bind four_axis_forward_kinematics_unit fk4_checker #(.OUT_W(OUT_W)) u_fk4_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fk4_pkg::*;

  localparam int IN_W  = 80;
  localparam int OUT_W = 240;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 40;    // more than the pipeline depth

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // turret_angle, lift_position, pan_angle, tilt_angle
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  // rot_00 .. rot_22, pos_x, pos_y, pos_z
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_write;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Shadow copy of the configuration registers
  logic [31:0] sh_lateral, sh_forward, sh_rail, sh_shift_z;
  logic [47:0] sh_rot [3];
  logic [63:0] sh_shift_xy;

  logic [OUT_W-1:0] pose_queue [$];
  int  errors;
  int  cycles;
  bit  quiet;       // no idling on either side when set
  int  stall_left;

  four_axis_forward_kinematics_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // a*b/2^30, truncated toward zero
  function automatic longint q30_mul(input longint a, input longint b);
    logic signed [127:0] wa, wb, p;
    logic [127:0] m;
    wa = a;
    wb = b;
    p = wa * wb;
    m = (p < 0) ? -p : p;
    m = m >> 30;
    return (p < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  // Taylor series sine/cosine with one half-turn reduction
  task automatic joint_sin_cos(input logic [15:0] a, output longint s, output longint c);
    longint x, x2, ts, tc;
    bit flip;
    x = longint'($signed(a)) * 64'sd131072;
    flip = 1'b0;
    ts = 64'sd1073741824;
    tc = 64'sd1073741824;
    if (x > 64'sd1686629713) begin
      x = x - 64'sd3373259426;
      flip = 1'b1;
    end else if (x < -64'sd1686629713) begin
      x = x + 64'sd3373259426;
      flip = 1'b1;
    end
    x2 = q30_mul(x, x);
    for (int k = 7; k >= 1; k--) begin
      ts = 64'sd1073741824 - q30_mul(x2, ts) / longint'((2 * k) * (2 * k + 1));
      tc = 64'sd1073741824 - q30_mul(x2, tc) / longint'((2 * k - 1) * (2 * k));
    end
    ts = q30_mul(x, ts);
    s = flip ? -ts : ts;
    c = flip ? -tc : tc;
  endtask

  // Camera pose for one joint vector under the shadow configuration
  task automatic camera_pose(input logic [IN_W-1:0] joints, output logic [OUT_W-1:0] pose);
    longint s1, c1, s2, c2, s3, c3, s12, c12, lat, rl, acc, p, mag, rr;
    longint rw [3][3];
    longint pw [3];
    longint hr [3][3];
    longint hs [3];
    joint_sin_cos(joints[15:0], s1, c1);
    joint_sin_cos(joints[63:48], s2, c2);
    joint_sin_cos(joints[79:64], s3, c3);
    s12 = q30_mul(s1, c2) + q30_mul(c1, s2);
    c12 = q30_mul(c1, c2) - q30_mul(s1, s2);
    rw[0][0] = -q30_mul(s12, c3); rw[0][1] = q30_mul(s12, s3);  rw[0][2] = c12;
    rw[1][0] = q30_mul(c12, c3);  rw[1][1] = -q30_mul(c12, s3); rw[1][2] = s12;
    rw[2][0] = s3;                rw[2][1] = c3;                rw[2][2] = 0;
    lat = longint'($signed(sh_lateral));
    rl = longint'($signed(sh_rail)) + longint'($signed(sh_forward));
    pw[0] = q30_mul(lat, c1) - q30_mul(rl, s1);
    pw[1] = q30_mul(lat, s1) + q30_mul(rl, c1);
    pw[2] = longint'($signed(joints[47:16]));
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        hr[k][j] = longint'($signed(sh_rot[k][16*j +: 16]));
    hs[0] = longint'($signed(sh_shift_xy[31:0]));
    hs[1] = longint'($signed(sh_shift_xy[63:32]));
    hs[2] = longint'($signed(sh_shift_z));
    for (int i = 0; i < 3; i++) begin
      p = pw[i];
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rw[i][k] * hr[k][j];
        // round to nearest, ties away from zero, then clamp to unit range
        mag = (((acc < 0) ? -acc : acc) + 64'sd536870912) >>> 30;
        if (mag > ROT_LIMIT) mag = ROT_LIMIT;
        rr = (acc < 0) ? -mag : mag;
        pose[16*(3*i+j) +: 16] = rr[15:0];
        p += q30_mul(hs[j], rw[i][j]);
      end
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      pose[144 + 32*i +: 32] = p[31:0];
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  // Compare every output transaction against the oldest expected pose
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pose_queue.size() == 0) begin
        report_mismatch("unexpected pose", 0, 0);
      end else begin
        want = pose_queue.pop_front();
        for (int f = 0; f < 9; f++)
          if (m_tdata[16*f +: 16] !== want[16*f +: 16])
            report_mismatch($sformatf("rot_%0d%0d", f / 3, f % 3),
                            $signed(m_tdata[16*f +: 16]), $signed(want[16*f +: 16]));
        for (int f = 0; f < 3; f++)
          if (m_tdata[144 + 32*f +: 32] !== want[144 + 32*f +: 32])
            report_mismatch($sformatf("pos_%s", (f == 0) ? "x" : (f == 1) ? "y" : "z"),
                            $signed(m_tdata[144 + 32*f +: 32]), $signed(want[144 + 32*f +: 32]));
      end
    end
  end

  // Receiver: stall in short random bursts unless quiet
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (!quiet && stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Send one joint vector; push its pose once the transaction is taken
  task automatic send_joints(input logic [15:0] turret, input logic [31:0] lift,
                             input logic [15:0] pan, input logic [15:0] tilt);
    logic [IN_W-1:0] joints;
    logic [OUT_W-1:0] pose;
    joints = {tilt, pan, lift, turret};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= joints;
    do @(posedge clk); while (!s_tready);
    camera_pose(joints, pose);
    pose_queue.push_back(pose);
  endtask

  // Drop valid and hold until every pose is back, then let the pipe settle
  task automatic drain_poses();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Load one register; the shadow copy keeps only the register's width
  task automatic load_reg(input cfg_reg_t idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LATERAL:  sh_lateral = value[31:0];
      REG_FORWARD:  sh_forward = value[31:0];
      REG_RAIL:     sh_rail = value[31:0];
      REG_ROT0:     sh_rot[0] = value[47:0];
      REG_ROT1:     sh_rot[1] = value[47:0];
      REG_ROT2:     sh_rot[2] = value[47:0];
      REG_SHIFT_XY: sh_shift_xy = value;
      REG_SHIFT_Z:  sh_shift_z = value[31:0];
      default: ;
    endcase
    // let the write enable drop before the next load
    @(posedge clk);
  endtask

  task automatic load_all(input logic [63:0] lat, input logic [63:0] fwd, input logic [63:0] rail,
                          input logic [63:0] r0, input logic [63:0] r1, input logic [63:0] r2,
                          input logic [63:0] sxy, input logic [63:0] sz);
    load_reg(REG_LATERAL, lat);
    load_reg(REG_FORWARD, fwd);
    load_reg(REG_RAIL, rail);
    load_reg(REG_ROT0, r0);
    load_reg(REG_ROT1, r1);
    load_reg(REG_ROT2, r2);
    load_reg(REG_SHIFT_XY, sxy);
    load_reg(REG_SHIFT_Z, sz);
  endtask

  function automatic logic [15:0] rand_angle();
    // mostly in the nominal range, sometimes any bit pattern
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 51472) - 25736);
  endfunction

  function automatic logic [31:0] rand_length();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 2000000) - 1000000);
      default: return 32'($signed(16'($urandom)) * 64);
    endcase
  endfunction

  function automatic logic [47:0] rand_rot_row();
    logic [47:0] row;
    for (int j = 0; j < 3; j++)
      row[16*j +: 16] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 32768) - 16384);
    return row;
  endfunction

  // Defaults after reset: identity hand rotation, zero offsets
  task automatic test_reset_config();
    send_joints(16'd0, 32'd0, 16'd0, 16'd0);
    send_joints(16'd6434, 32'h0001_0000, 16'hE6DE, 16'd3217);
    drain_poses();
  endtask

  // Angle extremes, half-turn reduction edges and lift extremes
  task automatic test_angle_edges();
    logic [15:0] edges [10] = '{16'd0, 16'd25736, 16'hA478, 16'h7FFF, 16'h8000,
                                16'd12867, 16'd12868, 16'hCDBD, 16'hCDBC, 16'd1};
    for (int i = 0; i < 10; i++)
      send_joints(edges[i], (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                  edges[(i + 3) % 10], edges[(i + 7) % 10]);
    drain_poses();
  endtask

  // Register extremes: saturating rotation entries and positions
  task automatic test_config_extremes();
    load_all(64'hFFFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
             64'hFFFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000, 64'h7FFF_8000_7FFF,
             64'h7FFF_FFFF_8000_0000, 64'h1234_5678_7FFF_FFFF);
    send_joints(16'd0, 32'h7FFF_FFFF, 16'd0, 16'd0);
    send_joints(16'd6434, 32'h8000_0000, 16'd6434, 16'hE6DE);
    send_joints(16'h8000, 32'd0, 16'h7FFF, 16'd12868);
    send_joints(16'd25736, 32'h4000_0000, 16'hA478, 16'd25736);
    drain_poses();
    load_all(64'h8000_0000, 64'h8000_0000, 64'h8000_0000,
             64'h0, 64'h0, 64'h0, 64'h8000_0000_8000_0000, 64'h8000_0000);
    send_joints(16'd3217, 32'h8000_0000, 16'd100, 16'hF000);
    send_joints(16'hE000, 32'h7FFF_FFFF, 16'd9000, 16'd20000);
    drain_poses();
  endtask

  // Random joint vectors over several random settings, then the default one with no idling
  task automatic test_random_poses();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4)
        load_all(64'h0, 64'h0, 64'h0, 64'h4000, 64'h4000_0000, 64'h4000_0000_0000,
                 64'h0, 64'h0);
      else
        load_all({$urandom, rand_length()}, {$urandom, rand_length()},
                 {$urandom, rand_length()}, {16'($urandom), rand_rot_row()},
                 {16'($urandom), rand_rot_row()}, {16'($urandom), rand_rot_row()},
                 {rand_length(), rand_length()}, {$urandom, rand_length()});
      quiet = (phase == 4);
      for (int n = 0; n < 100; n++) begin
        send_joints(rand_angle(), rand_length(), rand_angle(), rand_angle());
        // hold the sender once until the pipeline is empty
        if (phase == 1 && n == 50) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pose_queue.size() != 0) @(posedge clk);
        end
      end
      drain_poses();
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_write = 1'b0;
    cfg_index = REG_LATERAL;
    cfg_data = '0;
    sh_lateral = '0;
    sh_forward = '0;
    sh_rail = '0;
    sh_shift_z = '0;
    sh_shift_xy = '0;
    sh_rot[0] = 48'h0000_0000_4000;
    sh_rot[1] = 48'h0000_4000_0000;
    sh_rot[2] = 48'h4000_0000_0000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_angle_edges();
    test_config_extremes();
    test_random_poses();

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
